@@ hdl/ofs_pkg.sv @@
// Shared types and constants for the overlapping frame segmenter.
// Used by ofs_out_q and overlapping_frame_segmenter_core; no dependencies.
package ofs_pkg;

  // default sizing
  localparam int RING_DEPTH_DEF   = 256;
  localparam int MAX_SEGMENT_DEF  = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP          = 1'd1;

  localparam int SEG_SIZE_RESET = 64;
  localparam int HOP_RESET      = 32;

  // frame_kind codes
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // per-result flags that travel with each sample
  typedef struct packed {
    logic              last;
    logic              pad;
    logic [KIND_W-1:0] kind;
    logic              ovf;
  } res_flags_t;

endpackage

@@ hdl/ofs_out_q.sv @@
// Two-entry result queue between the frame sequencer and the output channel.
// Depends on ofs_pkg for res_flags_t.
module ofs_out_q
  import ofs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [SAMPLE_WIDTH-1:0] push_sample,
  input  res_flags_t              push_flags,
  output logic [1:0]              cnt,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_sample,
  output res_flags_t              out_flags
);

  logic [SAMPLE_WIDTH-1:0] q_sample [2];
  res_flags_t              q_flags  [2];
  logic                    wr_ptr;
  logic                    rd_ptr;

  assign out_valid  = (cnt != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign out_sample = q_sample[rd_ptr];
  assign out_flags  = q_flags[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_sample[wr_ptr] <= push_sample;
      q_flags[wr_ptr]  <= push_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push && cnt == 2'd2 |-> pop)
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("queue count out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 2'd1)
    else $error("queue count did not drop on pop");

endmodule

@@ hdl/overlapping_frame_segmenter_core.sv @@
// Overlapping frame segmenter: sample ring, frame sequencer and config registers.
// Depends on ofs_pkg and ofs_out_q.
//
// A sample write (mode 0) is taken back to back whenever the block is idle. A
// frame request (mode 1) holds in_stall high while the sequencer walks the ring:
// it issues one ring read per cycle while the output queue has room, through a
// single shared wrap-around pointer adder; results queue in a two-entry buffer,
// so the next request is taken as soon as the last read is issued. The ring has
// one write and one registered read port; its contents are not cleared at reset
// and need no clearing pass.
module overlapping_frame_segmenter_core
  import ofs_pkg::*;
#(
  parameter int RING_DEPTH   = RING_DEPTH_DEF,
  parameter int MAX_SEGMENT  = MAX_SEGMENT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    mode,
  input  logic [SAMPLE_WIDTH-1:0] sample_value,
  // configuration
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_sample,
  output logic                    last_of_frame,
  output logic                    is_padding,
  output logic [KIND_W-1:0]       frame_kind,
  output logic                    overflow_seen
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_SEGMENT + 1);
  localparam int SEG_RST = (SEG_SIZE_RESET > MAX_SEGMENT) ? MAX_SEGMENT : SEG_SIZE_RESET;
  localparam int HOP_RST = (HOP_RESET > MAX_SEGMENT) ? MAX_SEGMENT : HOP_RESET;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // config registers, held already clamped
  logic [LEN_W-1:0] seg_len;
  logic [LEN_W-1:0] hop_len;
  logic [LEN_W-1:0] cfg_clamped;

  // ring state
  logic [SAMPLE_WIDTH-1:0] ring [RING_DEPTH];
  logic [PTR_W-1:0]        rp;
  logic [PTR_W-1:0]        wp;
  logic [FILL_W-1:0]       fill;
  logic                    overflow;

  // sequencer
  logic                    state;
  logic [PTR_W-1:0]        rd_addr;
  logic [LEN_W-1:0]        cnt;
  logic [LEN_W-1:0]        run_len;
  logic [LEN_W-1:0]        held;
  logic [KIND_W-1:0]       req_kind;
  logic                    inflight;
  res_flags_t              pipe_flags;
  logic [SAMPLE_WIDTH-1:0] rd_data;

  logic                    accept;
  logic                    wr_req;
  logic                    fr_req;
  logic                    issue;
  logic                    last_issue;
  logic [LEN_W-1:0]        adv;
  logic                    is_full_frame;

  // shared wrap-around pointer adder
  logic [PTR_W-1:0]        add_a;
  logic [LEN_W-1:0]        add_b;
  logic [PTR_W:0]          add_sum;
  logic [PTR_W-1:0]        add_res;

  // output queue hookup
  logic [1:0]              q_cnt;
  logic                    q_pop;
  logic [SAMPLE_WIDTH-1:0] push_sample;
  res_flags_t              out_flags;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_req   = accept && !mode;
  assign fr_req   = accept && mode;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = LEN_W'(1);
    end else if (cfg_data > CFG_W'(MAX_SEGMENT)) begin
      cfg_clamped = LEN_W'(MAX_SEGMENT);
    end else begin
      cfg_clamped = cfg_data[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= LEN_W'(SEG_RST);
      hop_len <= LEN_W'(HOP_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEGMENT_SIZE: seg_len <= cfg_clamped;
        REG_HOP:          hop_len <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // frame decision on request
  assign is_full_frame = (fill > FILL_W'(seg_len));
  assign adv = (FILL_W'(hop_len) > fill) ? fill[LEN_W-1:0] : hop_len;

  always_comb begin
    if (state == ST_EMIT) begin
      add_a = rd_addr;
      add_b = LEN_W'(1);
    end else if (mode) begin
      add_a = rp;
      add_b = adv;
    end else begin
      add_a = wp;
      add_b = LEN_W'(1);
    end
    add_sum = {1'b0, add_a} + (PTR_W + 1)'(add_b);
    if (add_sum >= (PTR_W + 1)'(RING_DEPTH)) begin
      add_res = PTR_W'(add_sum - (PTR_W + 1)'(RING_DEPTH));
    end else begin
      add_res = add_sum[PTR_W-1:0];
    end
  end

  // a read may go out when the queue will have room for it by the time it is pushed
  assign issue      = (state == ST_EMIT) &&
                      (((q_cnt + 2'(inflight)) < 2'd2) || q_pop);
  assign last_issue = (cnt == run_len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (wr_req && fill < FILL_W'(RING_DEPTH)) begin
      ring[wp] <= sample_value;
    end
    if (issue) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pipe_flags.last <= last_issue;
      pipe_flags.pad  <= (req_kind == KIND_FLUSH) && (cnt >= held);
      pipe_flags.kind <= req_kind;
      pipe_flags.ovf  <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rp       <= '0;
      wp       <= '0;
      fill     <= '0;
      overflow <= 1'b0;
      inflight <= 1'b0;
      rd_addr  <= '0;
      cnt      <= '0;
      run_len  <= '0;
      held     <= '0;
      req_kind <= KIND_FULL;
    end else begin
      inflight <= issue;
      unique case (state)
        ST_IDLE: begin
          if (wr_req) begin
            if (fill >= FILL_W'(RING_DEPTH)) begin
              overflow <= 1'b1;
            end else begin
              wp   <= add_res;
              fill <= fill + FILL_W'(1);
            end
          end else if (fr_req) begin
            state   <= ST_EMIT;
            rd_addr <= rp;
            cnt     <= '0;
            if (fill == '0) begin
              req_kind <= KIND_EMPTY;
              run_len  <= LEN_W'(1);
              held     <= '0;
            end else if (is_full_frame) begin
              req_kind <= KIND_FULL;
              run_len  <= seg_len;
              held     <= '0;
              rp       <= add_res;
              fill     <= fill - FILL_W'(adv);
            end else begin
              // flush: everything held goes out, the rest is zero fill
              req_kind <= KIND_FLUSH;
              run_len  <= seg_len;
              held     <= fill[LEN_W-1:0];
              rp       <= wp;
              fill     <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            cnt     <= cnt + LEN_W'(1);
            rd_addr <= add_res;
            if (last_issue) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign push_sample = (pipe_flags.pad || pipe_flags.kind == KIND_EMPTY) ? '0 : rd_data;

  ofs_out_q #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_out_q (
    .clk        (clk),
    .rst        (rst),
    .push       (inflight),
    .push_sample(push_sample),
    .push_flags (pipe_flags),
    .cnt        (q_cnt),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_flags  (out_flags)
  );

  assign last_of_frame = out_flags.last;
  assign is_padding    = out_flags.pad;
  assign frame_kind    = out_flags.kind;
  assign overflow_seen = out_flags.ovf;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag cleared");

  a_emit_holds_ring: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && !issue |=> $stable(rd_addr) && $stable(cnt))
    else $error("sequencer moved without a read");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    issue |-> in_stall)
    else $error("ring read issued while taking requests");

endmodule

@@ tb/overlapping_frame_segmenter_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for overlapping_frame_segmenter_core: a frame tracker class
// predicts every output sample, plain tasks drive the ring writes and frame requests.
// Depends on ofs_pkg and the segmenter RTL.
module overlapping_frame_segmenter_core_tb;
  import ofs_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int RING          = RING_DEPTH_DEF;
  localparam int MAXSEG        = MAX_SEGMENT_DEF;
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_FRAME  = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [SW-1:0] smp;
    res_flags_t    flags;
  } frame_word_t;

  // Tracks ring contents and pointers, queues the samples each request should emit.
  class frame_tracker;
    logic [SW-1:0]    ring [RING];
    int unsigned      rd_ptr = 0;
    int unsigned      wr_ptr = 0;
    int unsigned      held = 0;
    bit               ovf = 1'b0;
    logic [CFG_W-1:0] seg_reg = CFG_W'(SEG_SIZE_RESET);
    logic [CFG_W-1:0] hop_reg = CFG_W'(HOP_RESET);
    frame_word_t      due [$];
    int               errors = 0;

    function int unsigned fit_len(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAXSEG) return MAXSEG;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SEGMENT_SIZE: seg_reg = val;
        REG_HOP:          hop_reg = val;
        default: ;
      endcase
    endfunction

    function void add_word(logic [SW-1:0] smp, logic last, logic pad, logic [KIND_W-1:0] kind);
      frame_word_t w;
      w.smp        = smp;
      w.flags.last = last;
      w.flags.pad  = pad;
      w.flags.kind = kind;
      w.flags.ovf  = ovf;
      due.push_back(w);
    endfunction

    function void take_request(logic m, logic [SW-1:0] v);
      int unsigned seg, adv;
      if (m == MODE_WRITE) begin
        if (held >= RING) begin
          ovf = 1'b1;
        end else begin
          ring[wr_ptr] = v;
          wr_ptr = (wr_ptr + 1) % RING;
          held++;
        end
      end else if (held == 0) begin
        add_word('0, 1'b1, 1'b0, KIND_EMPTY);
      end else begin
        seg = fit_len(seg_reg);
        if (held > seg) begin
          for (int unsigned i = 0; i < seg; i++)
            add_word(ring[(rd_ptr + i) % RING], i + 1 == seg, 1'b0, KIND_FULL);
          adv = fit_len(hop_reg);
          if (adv > held) adv = held;
          rd_ptr = (rd_ptr + adv) % RING;
          held -= adv;
        end else begin
          // flush: whatever is held, then zero fill
          for (int unsigned i = 0; i < seg; i++) begin
            if (i < held)
              add_word(ring[(rd_ptr + i) % RING], i + 1 == seg, 1'b0, KIND_FLUSH);
            else
              add_word('0, i + 1 == seg, 1'b1, KIND_FLUSH);
          end
          rd_ptr = wr_ptr;
          held = 0;
        end
      end
    endfunction

    function void check_field(string what, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void match_sample(logic [SW-1:0] smp, res_flags_t got);
      frame_word_t w;
      if (due.size() == 0) begin
        errors++;
        $display("%0t out_sample: expected none, actual %0d", $time, $signed(smp));
      end else begin
        w = due.pop_front();
        check_field("out_sample", $signed(w.smp), $signed(smp));
        check_field("last_of_frame", int'(w.flags.last), int'(got.last));
        check_field("is_padding", int'(w.flags.pad), int'(got.pad));
        check_field("frame_kind", int'(w.flags.kind), int'(got.kind));
        check_field("overflow_seen", int'(w.flags.ovf), int'(got.ovf));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = MODE_WRITE;
  logic [SW-1:0]        sample_value = '0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEGMENT_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SW-1:0]        out_sample;
  logic                 last_of_frame;
  logic                 is_padding;
  logic [KIND_W-1:0]    frame_kind;
  logic                 overflow_seen;

  bit           calm = 1'b0;
  int unsigned  cycles_run = 0;
  frame_tracker trk = new();

  overlapping_frame_segmenter_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .sample_value (sample_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .last_of_frame(last_of_frame),
    .is_padding   (is_padding),
    .frame_kind   (frame_kind),
    .overflow_seen(overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: check what is taken, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        trk.match_sample(out_sample, res_flags_t'{last: last_of_frame, pad: is_padding,
                                                  kind: frame_kind, ovf: overflow_seen});
      out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_req(logic m, logic [SW-1:0] v);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    trk.take_request(m, v);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (trk.due.size() != 0);
  endtask

  // writes may still be in flight after the last frame sample, so let it settle
  task automatic load_config(logic [CFG_W-1:0] seg, logic [CFG_W-1:0] hp);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SEGMENT_SIZE;
    cfg_data  <= seg;
    @(posedge clk);
    trk.set_reg(REG_SEGMENT_SIZE, seg);
    cfg_index <= REG_HOP;
    cfg_data  <= hp;
    @(posedge clk);
    trk.set_reg(REG_HOP, hp);
    cfg_write <= 1'b0;
  endtask

  // mostly write bursts followed by requests, some random noise in between
  task automatic run_phase(logic [CFG_W-1:0] seg, logic [CFG_W-1:0] hp, int quota, bit quiet);
    int   sent;
    int   burst;
    int   reqs;
    logic m;
    load_config(seg, hp);
    calm = quiet;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        burst = $urandom_range(0, 2 * trk.fit_len(seg) + 2);
        if (burst > RING - trk.held) burst = RING - trk.held;
        if (burst > quota - sent) burst = quota - sent;
        reqs = $urandom_range(1, 3);
        repeat (burst) send_req(MODE_WRITE, rand_sample());
        repeat (reqs) send_req(MODE_FRAME, rand_sample());
        sent += burst + reqs;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          m = (trk.held < RING && $urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_FRAME;
          send_req(m, rand_sample());
          sent++;
        end
      end
      if ($urandom_range(0, 39) == 0) wait_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset config 64/32: empty reply, then a short flush with padding
    send_req(MODE_FRAME, 16'h1234);
    send_req(MODE_WRITE, 16'h8000);
    send_req(MODE_WRITE, 16'h7FFF);
    send_req(MODE_WRITE, 16'h0000);
    send_req(MODE_WRITE, 16'hFFFF);
    send_req(MODE_WRITE, 16'h0001);
    send_req(MODE_FRAME, 16'hFFFF);

    // exactly segment_size held flushes, then full frame, flush, empty
    load_config(7'd4, 7'd2);
    repeat (4) send_req(MODE_WRITE, rand_sample());
    send_req(MODE_FRAME, rand_sample());
    repeat (6) send_req(MODE_WRITE, rand_sample());
    repeat (3) send_req(MODE_FRAME, rand_sample());

    // hop larger than what is held empties the ring
    load_config(7'd1, 7'd64);
    repeat (3) send_req(MODE_WRITE, rand_sample());
    repeat (2) send_req(MODE_FRAME, rand_sample());

    run_phase(7'd8, 7'd3, 16, 1'b0);
    run_phase(7'd0, 7'd0, 8, 1'b0);
    run_phase(7'd127, 7'd127, 12, 1'b0);
    run_phase(7'd1, 7'd1, 8, 1'b0);
    run_phase(7'd16, 7'd20, 25, 1'b1);
    run_phase(7'd33, 7'd7, 10, 1'b0);
    run_phase(7'd64, 7'd64, 8, 1'b0);
    run_phase(7'd5, 7'd64, 8, 1'b0);

    // fill the ring, overflow it, then drain with the sticky flag set
    load_config(7'd127, 7'd64);
    while (trk.held < RING) send_req(MODE_WRITE, rand_sample());
    repeat (3) send_req(MODE_WRITE, rand_sample());
    repeat (2) send_req(MODE_FRAME, rand_sample());
    send_req(MODE_WRITE, rand_sample());
    repeat (4) send_req(MODE_FRAME, rand_sample());

    wait_results();
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    if (trk.errors == 0 && trk.due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
